// ===== hw/rtl/vpr_pkg.sv =====
package vpr_pkg;

  localparam logic [7:0] ADDR_BASE      = 8'h80;
  localparam logic [7:0] ADDR_FIXED     = 8'h81;
  localparam logic [7:0] ADDR_BROADCAST = 8'h88;
  localparam logic [7:0] ADDR_UCAST_LO  = 8'h81;
  localparam logic [7:0] ADDR_UCAST_HI  = 8'h87;

  localparam int SLOT_W      = 7;
  localparam int MODES_W     = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] MAX_DEST_RESET = 3'd7;

  localparam logic [1:0] REG_ENABLE   = 2'd0;
  localparam logic [1:0] REG_MODES    = 2'd1;
  localparam logic [1:0] REG_MAX_DEST = 2'd2;

  typedef enum logic [1:0] {
    MODE_KEEP   = 2'd0,
    MODE_FIXED  = 2'd1,
    MODE_CAMERA = 2'd2
  } addr_mode_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  enable;
    logic [MODES_W-1:0] modes;
    logic [2:0]         max_dest;
  } cfg_t;

  // one queued transaction for the back end
  typedef struct packed {
    logic [7:0]        data;
    logic [SLOT_W-1:0] mask;
    logic              header;
    logic              pkt_end;
  } job_t;

endpackage

// ===== hw/rtl/vpr_front.sv =====
module vpr_front #(
  parameter int NUM_SLOTS        = 7,
  parameter int MAX_PACKET_BYTES = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  vpr_pkg::cfg_t cfg,
  input  logic          data_valid,
  input  logic          full,
  input  logic [7:0]    data_byte,
  input  logic          last_byte,
  output logic          push,
  output vpr_pkg::job_t job
);
  import vpr_pkg::*;

  localparam int PosW = $clog2(MAX_PACKET_BYTES + 1);
  localparam logic [PosW-1:0] MaxPos = PosW'(MAX_PACKET_BYTES);
  localparam logic [SLOT_W-1:0] SlotBits = SLOT_W'((1 << NUM_SLOTS) - 1);
  localparam bit OneByte = (MAX_PACKET_BYTES <= 1);

  logic [PosW-1:0]   pos;
  logic [SLOT_W-1:0] route_mask;

  logic              accept;
  logic [SLOT_W-1:0] en;
  logic [SLOT_W-1:0] bmask;
  logic [SLOT_W-1:0] umask;
  logic [SLOT_W-1:0] hdr_mask;
  logic [2:0]        cnt;
  logic [2:0]        uslot;
  logic              ucast;
  logic [PosW-1:0]   pos_inc;

  assign accept  = data_valid && !full;
  assign en      = cfg.enable & SlotBits;
  assign pos_inc = pos + 1'b1;

  always_comb begin
    bmask = '0;
    cnt   = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (en[i] && (cnt < cfg.max_dest)) begin
        bmask[i] = 1'b1;
        cnt      = cnt + 3'd1;
      end
    end
  end

  assign ucast = (data_byte >= ADDR_UCAST_LO) && (data_byte <= ADDR_UCAST_HI);
  assign uslot = data_byte[2:0] - 3'd1;
  assign umask = en & (SLOT_W'(1) << uslot);

  always_comb begin
    hdr_mask = '0;
    if (cfg.max_dest != 3'd0) begin
      if (data_byte == ADDR_BROADCAST) begin
        hdr_mask = bmask;
      end else if (ucast) begin
        hdr_mask = umask;
      end
    end
  end

  always_comb begin
    job  = '0;
    push = 1'b0;
    job.data = data_byte;
    if (pos == '0) begin
      job.mask    = hdr_mask;
      job.header  = 1'b1;
      job.pkt_end = last_byte || OneByte;
      push        = accept && (hdr_mask != '0);
    end else begin
      job.mask    = route_mask;
      job.header  = 1'b0;
      job.pkt_end = last_byte || (pos_inc == MaxPos);
      push        = accept && (route_mask != '0) && (pos < MaxPos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= '0;
      route_mask <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos        <= '0;
        route_mask <= '0;
      end else if (pos == '0) begin
        pos        <= PosW'(1);
        route_mask <= hdr_mask;
      end else if (pos < MaxPos) begin
        pos <= pos_inc;
      end
    end
  end

endmodule

// ===== hw/rtl/vpr_queue.sv =====
module vpr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vpr_pkg::job_t wr_job,
  input  logic          pop,
  output logic          full,
  output logic          nonempty,
  output vpr_pkg::job_t rd_job
);
  import vpr_pkg::*;

  localparam int PtrW = $clog2(QUEUE_DEPTH);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  job_t            mem [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign rd_job   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/vpr_back.sv =====
module vpr_back (
  input  logic          clk,
  input  logic          rst,
  input  vpr_pkg::cfg_t cfg,
  input  logic          q_nonempty,
  input  vpr_pkg::job_t q_job,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [7:0]    out_byte,
  output logic [6:0]    dest_mask,
  output logic          is_header,
  output logic          packet_end,
  output logic          run_end
);
  import vpr_pkg::*;

  back_state_t state, state_next;
  job_t        cur;

  logic              slot_free;
  logic              emit;
  logic              done;
  logic [SLOT_W-1:0] lowest;
  logic [SLOT_W-1:0] rem_after;
  logic [2:0]        slot;
  addr_mode_t        mode;
  logic [7:0]        hdr_byte;
  logic [7:0]        res_byte;
  logic [SLOT_W-1:0] res_mask;

  assign slot_free = !result_valid || !result_stall;
  assign emit      = (state == BK_RUN) && slot_free;

  // walk destinations lowest slot first
  assign lowest    = cur.mask & (~cur.mask + 1'b1);
  assign rem_after = cur.mask & ~lowest;
  assign done      = cur.header ? (rem_after == '0) : 1'b1;

  always_comb begin
    slot = '0;
    for (int i = 0; i < SLOT_W; i++) begin
      if (lowest[i]) begin
        slot = 3'(i);
      end
    end
  end

  assign mode = addr_mode_t'(2'(cfg.modes >> {slot, 1'b0}));

  always_comb begin
    case (mode)
      MODE_FIXED:  hdr_byte = ADDR_FIXED;
      MODE_CAMERA: hdr_byte = ADDR_BASE | {4'b0, {1'b0, slot} + 4'd1};
      default:     hdr_byte = cur.data;
    endcase
  end

  assign res_byte = cur.header ? hdr_byte : cur.data;
  assign res_mask = cur.header ? lowest : cur.mask;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (q_nonempty) begin
          pop        = 1'b1;
          state_next = BK_RUN;
        end
      end
      BK_RUN: begin
        if (emit && done) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end else if (emit) begin
      cur.mask <= rem_after;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte   <= res_byte;
      dest_mask  <= res_mask;
      is_header  <= cur.header;
      packet_end <= cur.pkt_end;
      run_end    <= done;
    end
  end

endmodule

// ===== hw/rtl/visca_packet_router.sv =====
// An accepted byte is queued (dropped bytes are not) and popped into the back end's
// job register while it is idle; each result is registered at the output. A header
// byte yields one result per destination (up to 7), a later byte one, held while
// result_stall is high. data_stall rises only while the 2-entry queue is full.
// Reset (synchronous): queue, routing state and output valid clear;
// registers return to enable 0, modes 0, max_destinations 7.
module visca_packet_router #(
  parameter int NUM_SLOTS        = 7,
  parameter int MAX_PACKET_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic [6:0]  dest_mask,
  output logic        is_header,
  output logic        packet_end,
  output logic        run_end
);
  import vpr_pkg::*;

  cfg_t cfg;
  job_t front_job;
  job_t q_job;
  logic front_push;
  logic q_full;
  logic q_nonempty;
  logic back_pop;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable   <= '0;
      cfg.modes    <= '0;
      cfg.max_dest <= MAX_DEST_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ENABLE:   cfg.enable   <= pwdata[SLOT_W-1:0];
        REG_MODES:    cfg.modes    <= pwdata[MODES_W-1:0];
        REG_MAX_DEST: cfg.max_dest <= pwdata[2:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ENABLE:   prdata = 32'(cfg.enable);
      REG_MODES:    prdata = 32'(cfg.modes);
      REG_MAX_DEST: prdata = 32'(cfg.max_dest);
      default:      prdata = '0;
    endcase
  end

  assign data_stall = q_full;

  vpr_front #(
    .NUM_SLOTS        (NUM_SLOTS),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .data_valid (data_valid),
    .full       (q_full),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .push       (front_push),
    .job        (front_job)
  );

  vpr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .wr_job   (front_job),
    .pop      (back_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .rd_job   (q_job)
  );

  vpr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_nonempty   (q_nonempty),
    .q_job        (q_job),
    .pop          (back_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .dest_mask    (dest_mask),
    .is_header    (is_header),
    .packet_end   (packet_end),
    .run_end      (run_end)
  );

endmodule

// ===== tb/sv/visca_packet_router_test.sv =====
module visca_packet_router_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vpr_pkg::*;

  localparam int SLOTS    = 7;
  localparam int PKT_MAX  = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int NUM_ROWS = 29;
  localparam int PHASE_BYTES = 19;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] mask;
    logic       hdr;
    logic       pend;
    logic       rend;
  } route_res_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NONE,
    ROW_TYPED,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] data;
    logic       last;
    route_res_t typed;
    logic [1:0] reg_idx;
    logic [31:0] value;
  } stim_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        data_valid;
  logic        data_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        result_valid;
  logic        result_stall;
  logic [7:0]  out_byte;
  logic [6:0]  dest_mask;
  logic        is_header;
  logic        packet_end;
  logic        run_end;

  // predictor copy of registers and routing state
  logic [6:0]  cfg_enable;
  logic [13:0] cfg_modes;
  logic [2:0]  cfg_max_dest;
  logic [6:0]  cur_route;
  logic [4:0]  cur_pos;

  route_res_t  pending_routes[$];
  int          errors;
  int          idle_pct;
  int          stall_pct;
  int          send_calm;
  int          recv_calm;
  int          quiet_cycles;

  visca_packet_router #(
    .NUM_SLOTS(SLOTS),
    .MAX_PACKET_BYTES(PKT_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .data_valid(data_valid),
    .data_stall(data_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte(out_byte),
    .dest_mask(dest_mask),
    .is_header(is_header),
    .packet_end(packet_end),
    .run_end(run_end)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Routes one byte through the predictor; queues the results when asked.
  function automatic int route_byte(input logic [7:0] b, input logic l, input bit keep);
    logic [6:0] hit;
    logic [1:0] mode;
    int         cnt;
    int         n;
    route_res_t r;
    hit = '0;
    cnt = 0;
    n = 0;
    if (cur_pos == 0) begin
      if (cfg_max_dest != 0) begin
        if (b == ADDR_BROADCAST) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (cfg_enable[i] && cnt < cfg_max_dest) begin
              hit[i] = 1'b1;
              cnt++;
            end
          end
        end else if (b >= ADDR_UCAST_LO && b <= ADDR_UCAST_HI) begin
          if (cfg_enable[b - ADDR_UCAST_LO]) hit[b - ADDR_UCAST_LO] = 1'b1;
        end
      end
      for (int i = 0; i < SLOTS; i++) begin
        if (hit[i]) begin
          mode = cfg_modes[2*i +: 2];
          if (mode == MODE_FIXED) r.data = ADDR_FIXED;
          else if (mode == MODE_CAMERA) r.data = ADDR_BASE | 8'(i + 1);
          else r.data = b;
          r.mask = '0;
          r.mask[i] = 1'b1;
          r.hdr = 1'b1;
          r.pend = l;
          r.rend = ((hit >> (i + 1)) == 7'd0);
          n++;
          if (keep) pending_routes.push_back(r);
        end
      end
      cur_route = l ? 7'd0 : hit;
      cur_pos = l ? 5'd0 : 5'd1;
    end else begin
      if (cur_route != 0 && cur_pos < PKT_MAX) begin
        r.data = b;
        r.mask = cur_route;
        r.hdr = 1'b0;
        r.pend = l || (cur_pos + 1 == PKT_MAX);
        r.rend = 1'b1;
        n = 1;
        if (keep) pending_routes.push_back(r);
      end
      if (l) begin
        cur_route = '0;
        cur_pos = '0;
      end else if (cur_pos < PKT_MAX) begin
        cur_pos = cur_pos + 5'd1;
      end
    end
    return n;
  endfunction

  function automatic stim_row_t row_cfg(input logic [1:0] idx, input logic [31:0] v);
    stim_row_t s;
    s = '0;
    s.kind = ROW_CFG;
    s.reg_idx = idx;
    s.value = v;
    return s;
  endfunction

  function automatic stim_row_t row_byte(input row_kind_t k, input logic [7:0] b,
                                         input logic l, input route_res_t t);
    stim_row_t s;
    s = '0;
    s.kind = k;
    s.data = b;
    s.last = l;
    s.typed = t;
    return s;
  endfunction

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ENABLE:   cfg_enable = v[6:0];
      REG_MODES:    cfg_modes = v[13:0];
      REG_MAX_DEST: cfg_max_dest = v[2:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  // block must be drained before a register write; dropped bytes may still be in flight
  task automatic wait_idle();
    data_valid <= 1'b0;
    while (pending_routes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic drive_byte(input logic [7:0] b, input logic l, input row_kind_t k,
                            input route_res_t t);
    if (send_calm > 0) send_calm--;
    else if ($urandom_range(0, 31) == 0) send_calm = $urandom_range(8, 24);
    while (send_calm == 0 && $urandom_range(0, 99) < idle_pct) begin
      data_valid <= 1'b0;
      @(negedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= b;
    last_byte <= l;
    do @(posedge clk); while (data_stall);
    void'(route_byte(b, l, k == ROW_PREDICT));
    if (k == ROW_TYPED) pending_routes.push_back(t);
    @(negedge clk);
  endtask

  // mostly well-formed packets, some garbage addresses; a few run past truncation
  task automatic send_packet(inout int sent);
    logic [7:0] addr;
    int         len;
    int         pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) addr = ADDR_BROADCAST;
    else if (pick < 8) addr = 8'($urandom_range(ADDR_UCAST_LO, ADDR_UCAST_HI));
    else addr = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 9);
    if (pick < 7) len = $urandom_range(1, 5);
    else if (pick < 9) len = $urandom_range(6, 15);
    else len = $urandom_range(16, 20);
    drive_byte(addr, len == 1, ROW_PREDICT, '0);
    sent++;
    for (int i = 1; i < len; i++) begin
      drive_byte(8'($urandom_range(0, 255)), i == len - 1, ROW_PREDICT, '0);
      sent++;
    end
  endtask

  initial result_stall = 1'b0;

  always @(negedge clk) begin
    if (recv_calm > 0) begin
      recv_calm <= recv_calm - 1;
      result_stall <= 1'b0;
    end else if ($urandom_range(0, 63) == 0) begin
      recv_calm <= $urandom_range(10, 30);
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    route_res_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_routes.size() == 0) begin
        $error("unexpected result transaction: out_byte %0h dest_mask %0h", out_byte,
               dest_mask);
        errors++;
      end else begin
        want = pending_routes.pop_front();
        if (out_byte !== want.data) begin
          $error("out_byte: expected %0h, got %0h", want.data, out_byte);
          errors++;
        end
        if (dest_mask !== want.mask) begin
          $error("dest_mask: expected %0h, got %0h", want.mask, dest_mask);
          errors++;
        end
        if (is_header !== want.hdr) begin
          $error("is_header: expected %0b, got %0b", want.hdr, is_header);
          errors++;
        end
        if (packet_end !== want.pend) begin
          $error("packet_end: expected %0b, got %0b", want.pend, packet_end);
          errors++;
        end
        if (run_end !== want.rend) begin
          $error("run_end: expected %0b, got %0b", want.rend, run_end);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (result_valid && !result_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t directed[NUM_ROWS];
    int        sent;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    data_valid = 1'b0;
    data_byte = '0;
    last_byte = 1'b0;
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    send_calm = 0;
    recv_calm = 0;
    quiet_cycles = 0;
    cfg_enable = '0;
    cfg_modes = '0;
    cfg_max_dest = MAX_DEST_RESET;
    cur_route = '0;
    cur_pos = '0;

    directed = '{
      // reset state: nothing enabled, so nothing is routed
      row_byte(ROW_NONE, ADDR_BROADCAST, 1'b1, '0),
      row_byte(ROW_NONE, 8'h81, 1'b0, '0),
      row_byte(ROW_NONE, 8'hFF, 1'b0, '0),
      row_byte(ROW_NONE, 8'h00, 1'b1, '0),
      row_cfg(REG_ENABLE, 32'h7F),
      // slots: fixed, camera, mode 3, keep, fixed, camera, mode 3
      row_cfg(REG_MODES, 32'h3939),
      row_byte(ROW_PREDICT, ADDR_BROADCAST, 1'b0, '0),
      row_byte(ROW_PREDICT, 8'h00, 1'b0, '0),
      row_byte(ROW_PREDICT, 8'hFF, 1'b1, '0),
      row_byte(ROW_TYPED, 8'h87, 1'b1, '{8'h87, 7'h40, 1'b1, 1'b1, 1'b1}),
      row_byte(ROW_NONE, 8'h80, 1'b1, '0),
      row_byte(ROW_NONE, 8'h89, 1'b1, '0),
      row_byte(ROW_TYPED, 8'h82, 1'b0, '{8'h82, 7'h02, 1'b1, 1'b0, 1'b1}),
      row_byte(ROW_TYPED, 8'h3C, 1'b1, '{8'h3C, 7'h02, 1'b0, 1'b1, 1'b1}),
      row_cfg(REG_MAX_DEST, 32'h0),
      row_byte(ROW_NONE, ADDR_BROADCAST, 1'b1, '0),
      row_byte(ROW_NONE, 8'h81, 1'b0, '0),
      row_byte(ROW_NONE, 8'h55, 1'b1, '0),
      row_cfg(REG_ENABLE, 32'h55),
      row_cfg(REG_MAX_DEST, 32'h2),
      row_byte(ROW_PREDICT, ADDR_BROADCAST, 1'b1, '0),
      row_byte(ROW_NONE, 8'h82, 1'b1, '0),
      row_cfg(REG_MODES, 32'h2AAA),
      row_cfg(REG_ENABLE, 32'h7F),
      row_cfg(REG_MAX_DEST, 32'h7),
      row_byte(ROW_PREDICT, ADDR_BROADCAST, 1'b0, '0),
      row_byte(ROW_PREDICT, 8'hA5, 1'b1, '0),
      row_byte(ROW_PREDICT, 8'h81, 1'b0, '0),
      row_byte(ROW_PREDICT, 8'h7E, 1'b1, '0)
    };

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        wait_idle();
        apb_write(directed[i].reg_idx, directed[i].value);
      end else begin
        drive_byte(directed[i].data, directed[i].last, directed[i].kind,
                   directed[i].typed);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          apb_write(REG_ENABLE, 32'h7F);
          apb_write(REG_MODES, 32'h3FFF);
          apb_write(REG_MAX_DEST, 32'h7);
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          apb_write(REG_ENABLE, $urandom_range(1, 127));
          apb_write(REG_MODES, $urandom_range(0, 16383));
          apb_write(REG_MAX_DEST, $urandom_range(1, 7));
          idle_pct = 54;
          stall_pct = 0;
        end
        2: begin
          apb_write(REG_ENABLE, $urandom_range(1, 127));
          apb_write(REG_MODES, $urandom_range(0, 16383));
          apb_write(REG_MAX_DEST, 32'h1);
          idle_pct = 0;
          stall_pct = 54;
        end
        default: begin
          apb_write(REG_ENABLE, $urandom_range(1, 127));
          apb_write(REG_MODES, 32'h0);
          apb_write(REG_MAX_DEST, $urandom_range(1, 7));
          idle_pct = 35;
          stall_pct = 35;
        end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) send_packet(sent);
    end

    data_valid <= 1'b0;
    while (pending_routes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/vpr_pkg.sv
hw/rtl/vpr_front.sv
hw/rtl/vpr_queue.sv
hw/rtl/vpr_back.sv
hw/rtl/visca_packet_router.sv
tb/sv/visca_packet_router_test.sv
